/* hw/rtl/irlp_pkg.sv */
// Shared types and constants for the IMAP response line parser.
`timescale 1ns / 1ps

package irlp_pkg;

  typedef enum logic [1:0] {
    LK_UNDECIDED = 2'd0,
    LK_UNTAGGED  = 2'd1,
    LK_TAG       = 2'd2,
    LK_UNKNOWN   = 2'd3
  } line_kind_t;

  typedef enum logic [1:0] {
    TS_NONE    = 2'd0,
    TS_DIGITS  = 2'd1,
    TS_FAILED  = 2'd2,
    TS_MATCHED = 2'd3
  } tag_status_t;

  typedef enum logic [1:0] {
    AP_IDLE      = 2'd0,
    AP_SEEK      = 2'd1,
    AP_IN_PARENS = 2'd2,
    AP_DONE      = 2'd3
  } attr_phase_t;

  typedef enum logic [3:0] {
    LP_PREFIX     = 4'd0,
    LP_SEEK_CLOSE = 4'd1,
    LP_SKIP_SP    = 4'd2,
    LP_DELIM      = 4'd3,
    LP_DELIM_SP   = 4'd4,
    LP_OPEN_Q     = 4'd5,
    LP_NAME       = 4'd6,
    LP_NAME_END   = 4'd7,
    LP_NONE       = 4'd8
  } list_phase_t;

  localparam logic [1:0] CLASS_UNTAGGED = 2'd0;
  localparam logic [1:0] CLASS_TAGGED   = 2'd1;
  localparam logic [1:0] CLASS_UNKNOWN  = 2'd2;

  localparam logic [3:0] FLAG_BOUNDARY = 4'd0;
  localparam logic [3:0] FLAG_FULL     = 4'd9;
  localparam logic [3:0] FLAG_SKIP     = 4'd15;
  localparam logic [3:0] POS_MAX       = 4'd15;
  localparam logic [3:0] LIST_LEN      = 4'd7;
  localparam logic [1:0] OK_LEN        = 2'd3;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  localparam logic [7:0] LIST_PAT [0:6] = '{8'h2A, 8'h20, 8'h4C, 8'h49, 8'h53, 8'h54, 8'h20};
  localparam logic [7:0] OK_PAT   [0:2] = '{8'h4F, 8'h4B, 8'h20};
  localparam logic [7:0] NOSEL_PAT [0:8] =
    '{8'h5C, 8'h4E, 8'h6F, 8'h73, 8'h65, 8'h6C, 8'h65, 8'h63, 8'h74};

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_valid;
    logic       line_done;
    logic [1:0] line_class;
    logic       tag_ok;
    logic       list_line;
    logic       folder_found;
    logic       noselect;
  } line_result_t;

endpackage

/* hw/rtl/imap_response_line_parser.sv */
// Top level: input register, parse core, result register, tag register.
`timescale 1ns / 1ps

// Parses one IMAP response line per run of input beats, one byte per beat,
// with last marking the final byte. Every input beat yields exactly one
// result beat: folder name bytes stream out as they pass, and on the final
// byte the line summary (class, tagged OK, LIST, folder found, \Noselect)
// is valid. One byte per cycle is taken while out_ready does not stall
// the result register. The accepting edge loads the input register, and
// a later step runs the state update of the parse core into the result
// register. expected_tag is written through cfg_we/cfg_data; the user must
// write it only between lines, as the block does not enforce this.

module imap_response_line_parser import irlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  name_byte,
  output logic        name_valid,
  output logic        line_done,
  output logic [1:0]  line_class,
  output logic        tag_ok,
  output logic        list_line,
  output logic        folder_found,
  output logic        noselect,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  logic [31:0]  expected_tag;
  logic         in_held;
  logic [7:0]   char_q;
  logic         last_q;
  logic         step;
  line_result_t res;
  line_result_t res_q;

  assign step     = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || step;

  always_ff @(posedge clk) begin
    if (rst) expected_tag <= '0;
    else if (cfg_we) expected_tag <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) in_held <= 1'b0;
    else if (in_ready) in_held <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_in;
      last_q <= last;
    end
  end

  irlp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .char_in      (char_q),
    .last         (last_q),
    .expected_tag (expected_tag),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (step) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) res_q <= res;
  end

  assign name_byte    = res_q.name_byte;
  assign name_valid   = res_q.name_valid;
  assign line_done    = res_q.line_done;
  assign line_class   = res_q.line_class;
  assign tag_ok       = res_q.tag_ok;
  assign list_line    = res_q.list_line;
  assign folder_found = res_q.folder_found;
  assign noselect     = res_q.noselect;

endmodule

/* hw/rtl/irlp_core.sv */
// Per-line parse state and the single-pass byte update.
`timescale 1ns / 1ps

module irlp_core import irlp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   char_in,
  input  logic         last,
  input  logic [31:0]  expected_tag,
  output line_result_t res
);

  logic [3:0]  byte_pos, byte_pos_next;
  line_kind_t  line_kind, line_kind_next;
  logic [31:0] tag_acc, tag_acc_next;
  tag_status_t tag_status, tag_status_next;
  logic [1:0]  ok_pos, ok_pos_next;
  logic        ok_dead, ok_dead_next;
  list_phase_t list_phase, list_phase_next;
  attr_phase_t attr_phase, attr_phase_next;
  logic [3:0]  flag_pos, flag_pos_next;
  logic [3:0]  flags, flags_next;

  logic        digit;
  logic [35:0] tag_prod;

  assign digit    = char_in inside {[8'h30:8'h39]};
  // acc * 10 + digit, wide enough to see overflow past 32 bits
  assign tag_prod = ({4'b0, tag_acc} << 3) + ({4'b0, tag_acc} << 1) + {32'b0, char_in[3:0]};

  always_comb begin
    logic [3:0] f;
    byte_pos_next   = byte_pos;
    line_kind_next  = line_kind;
    tag_acc_next    = tag_acc;
    tag_status_next = tag_status;
    ok_pos_next     = ok_pos;
    ok_dead_next    = ok_dead;
    list_phase_next = list_phase;
    attr_phase_next = attr_phase;
    flags_next      = flags;
    f               = flag_pos;
    res             = '0;

    // line class and tag
    if (byte_pos == 4'd0) begin
      if (char_in == CH_STAR) begin
        line_kind_next = LK_UNDECIDED;
      end else if (digit) begin
        line_kind_next  = LK_TAG;
        tag_status_next = TS_DIGITS;
        tag_acc_next    = {28'b0, char_in[3:0]};
      end else begin
        line_kind_next = LK_UNKNOWN;
      end
    end else if (line_kind == LK_UNDECIDED) begin
      line_kind_next = (char_in == CH_SPACE) ? LK_UNTAGGED : LK_UNKNOWN;
    end else if (line_kind == LK_TAG) begin
      if (tag_status == TS_DIGITS) begin
        if (digit) begin
          // leading zero or overflow kills the tag
          if (tag_acc == 32'd0 || tag_prod[35:32] != 4'd0) tag_status_next = TS_FAILED;
          else tag_acc_next = tag_prod[31:0];
        end else if (char_in == CH_SPACE) begin
          tag_status_next = (tag_acc == expected_tag) ? TS_MATCHED : TS_FAILED;
        end else begin
          tag_status_next = TS_FAILED;
        end
      end else if (tag_status == TS_MATCHED && !ok_dead && ok_pos < OK_LEN) begin
        if (char_in == OK_PAT[ok_pos]) begin
          ok_pos_next = ok_pos + 2'd1;
          if (ok_pos_next == OK_LEN) flags_next[0] = 1'b1;
        end else begin
          ok_dead_next = 1'b1;
        end
      end
    end

    // folder name field
    case (list_phase)
      LP_SEEK_CLOSE: begin
        if (char_in == CH_RPAREN) list_phase_next = LP_SKIP_SP;
      end
      LP_SKIP_SP: begin
        if (char_in == CH_QUOTE) list_phase_next = LP_DELIM;
        else if (char_in != CH_SPACE) list_phase_next = LP_NONE;
      end
      LP_DELIM: begin
        if (char_in == CH_QUOTE) list_phase_next = LP_DELIM_SP;
      end
      LP_DELIM_SP: begin
        list_phase_next = (char_in == CH_SPACE) ? LP_OPEN_Q : LP_NONE;
      end
      LP_OPEN_Q: begin
        if (char_in == CH_QUOTE) begin
          list_phase_next = LP_NAME;
          flags_next[2]   = 1'b1;
        end else begin
          list_phase_next = LP_NONE;
        end
      end
      LP_NAME: begin
        if (char_in == CH_QUOTE) begin
          list_phase_next = LP_NAME_END;
        end else begin
          res.name_byte  = char_in;
          res.name_valid = 1'b1;
        end
      end
      default: ;
    endcase

    // attribute scan, confined to the parentheses
    if (attr_phase == AP_SEEK) begin
      if (char_in == CH_LPAREN) begin
        attr_phase_next = AP_IN_PARENS;
        f = FLAG_BOUNDARY;
      end
    end else if (attr_phase == AP_IN_PARENS) begin
      if (f == FLAG_BOUNDARY) begin
        if (char_in == CH_RPAREN) attr_phase_next = AP_DONE;
        else if (char_in != CH_SPACE) f = (char_in == NOSEL_PAT[0]) ? 4'd1 : FLAG_SKIP;
      end else if (f == FLAG_SKIP) begin
        if (char_in == CH_SPACE) f = FLAG_BOUNDARY;
        else if (char_in == CH_RPAREN) attr_phase_next = AP_DONE;
      end else if (f < FLAG_FULL) begin
        if (char_in == NOSEL_PAT[f]) begin
          f = f + 4'd1;
          if (f == FLAG_FULL) begin
            flags_next[3]   = 1'b1;
            attr_phase_next = AP_DONE;
          end
        end else if (char_in == CH_SPACE) begin
          f = FLAG_BOUNDARY;
        end else if (char_in == CH_RPAREN) begin
          attr_phase_next = AP_DONE;
        end else begin
          f = FLAG_SKIP;
        end
      end
    end
    flag_pos_next = f;

    // "* LIST " prefix
    if (list_phase == LP_PREFIX) begin
      if (byte_pos < LIST_LEN && char_in == LIST_PAT[byte_pos[2:0]]) begin
        if (byte_pos == LIST_LEN - 4'd1) begin
          list_phase_next = LP_SEEK_CLOSE;
          attr_phase_next = AP_SEEK;
          flags_next[1]   = 1'b1;
        end
      end else begin
        list_phase_next = LP_NONE;
      end
    end

    if (byte_pos < POS_MAX) byte_pos_next = byte_pos + 4'd1;

    res.line_done = last;
    if (last) begin
      if (line_kind_next == LK_UNTAGGED) res.line_class = CLASS_UNTAGGED;
      else if (line_kind_next == LK_TAG && tag_status_next == TS_MATCHED)
        res.line_class = CLASS_TAGGED;
      else res.line_class = CLASS_UNKNOWN;
      res.tag_ok       = flags_next[0];
      res.list_line    = flags_next[1];
      res.folder_found = flags_next[2];
      res.noselect     = flags_next[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_pos   <= '0;
      line_kind  <= LK_UNDECIDED;
      tag_acc    <= '0;
      tag_status <= TS_NONE;
      ok_pos     <= '0;
      ok_dead    <= 1'b0;
      list_phase <= LP_PREFIX;
      attr_phase <= AP_IDLE;
      flag_pos   <= FLAG_BOUNDARY;
      flags      <= '0;
    end else if (step) begin
      byte_pos   <= byte_pos_next;
      line_kind  <= line_kind_next;
      tag_acc    <= tag_acc_next;
      tag_status <= tag_status_next;
      ok_pos     <= ok_pos_next;
      ok_dead    <= ok_dead_next;
      list_phase <= list_phase_next;
      attr_phase <= attr_phase_next;
      flag_pos   <= flag_pos_next;
      flags      <= flags_next;
    end
  end

endmodule

/* tb/tb_imap_response_line_parser.sv */
// Testbench for imap_response_line_parser: directed lines, then random lines.
`timescale 1ns / 1ps

module tb_imap_response_line_parser;
  import irlp_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam int PHASE_BYTES = 90;

  localparam logic [7:0] LIST_WORD [0:6] = '{"*", " ", "L", "I", "S", "T", " "};
  localparam logic [7:0] OK_WORD [0:2] = '{"O", "K", " "};
  localparam logic [7:0] NOSEL_WORD [0:8] = '{"\\", "N", "o", "s", "e", "l", "e", "c", "t"};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  name_byte;
  logic        name_valid;
  logic        line_done;
  logic [1:0]  line_class;
  logic        tag_ok;
  logic        list_line;
  logic        folder_found;
  logic        noselect;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = 32'h0;

  imap_response_line_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .name_byte    (name_byte),
    .name_valid   (name_valid),
    .line_done    (line_done),
    .line_class   (line_class),
    .tag_ok       (tag_ok),
    .list_line    (list_line),
    .folder_found (folder_found),
    .noselect     (noselect),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // typed-in expectation travels with the beat it belongs to
  logic         row_typed = 1'b0;
  line_result_t row_exp = '0;

  line_result_t expected_results [$];
  logic [7:0]   byte_q [$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  int           bytes_sent = 0;

  // line parser model state
  logic [31:0]  tag_shadow = 32'h0;
  logic [3:0]   pk_pos;
  line_kind_t   pk_kind;
  tag_status_t  pk_tag_st;
  logic [31:0]  pk_tag_acc;
  logic [1:0]   pk_ok_pos;
  logic         pk_ok_dead;
  list_phase_t  pk_list;
  attr_phase_t  pk_attr;
  logic [3:0]   pk_flag_pos;
  logic         pk_tag_ok, pk_list_line, pk_folder, pk_nosel;

  function automatic void clear_parse_state();
    pk_pos = '0;
    pk_kind = LK_UNDECIDED;
    pk_tag_st = TS_NONE;
    pk_tag_acc = '0;
    pk_ok_pos = '0;
    pk_ok_dead = 1'b0;
    pk_list = LP_PREFIX;
    pk_attr = AP_IDLE;
    pk_flag_pos = FLAG_BOUNDARY;
    pk_tag_ok = 1'b0;
    pk_list_line = 1'b0;
    pk_folder = 1'b0;
    pk_nosel = 1'b0;
  endfunction

  function automatic line_result_t parse_byte(input logic [7:0] c, input logic lst);
    line_result_t r;
    logic         dig;
    logic [35:0]  acc10;
    logic [3:0]   f;
    r = '0;
    dig = (c >= "0") && (c <= "9");
    acc10 = {4'h0, pk_tag_acc} * 36'd10 + {28'h0, c} - 36'h30;

    // line class and tag
    if (pk_pos == 4'd0) begin
      if (c == CH_STAR) begin
        pk_kind = LK_UNDECIDED;
      end else if (dig) begin
        pk_kind = LK_TAG;
        pk_tag_st = TS_DIGITS;
        pk_tag_acc = {24'h0, c - 8'h30};
      end else begin
        pk_kind = LK_UNKNOWN;
      end
    end else if (pk_kind == LK_UNDECIDED) begin
      if (c == CH_SPACE) pk_kind = LK_UNTAGGED;
      else pk_kind = LK_UNKNOWN;
    end else if (pk_kind == LK_TAG) begin
      if (pk_tag_st == TS_DIGITS) begin
        if (dig) begin
          // leading zero or 32-bit overflow kills the tag
          if (pk_tag_acc == 32'd0 || acc10 > 36'hFFFF_FFFF) pk_tag_st = TS_FAILED;
          else pk_tag_acc = acc10[31:0];
        end else if (c == CH_SPACE) begin
          if (pk_tag_acc == tag_shadow) pk_tag_st = TS_MATCHED;
          else pk_tag_st = TS_FAILED;
        end else begin
          pk_tag_st = TS_FAILED;
        end
      end else if (pk_tag_st == TS_MATCHED && !pk_ok_dead && pk_ok_pos < OK_LEN) begin
        if (c == OK_WORD[pk_ok_pos]) begin
          pk_ok_pos = pk_ok_pos + 2'd1;
          if (pk_ok_pos == OK_LEN) pk_tag_ok = 1'b1;
        end else begin
          pk_ok_dead = 1'b1;
        end
      end
    end

    // folder name: ')' spaces "delim" space "name"
    case (pk_list)
      LP_SEEK_CLOSE: if (c == CH_RPAREN) pk_list = LP_SKIP_SP;
      LP_SKIP_SP: begin
        if (c == CH_QUOTE) pk_list = LP_DELIM;
        else if (c != CH_SPACE) pk_list = LP_NONE;
      end
      LP_DELIM: if (c == CH_QUOTE) pk_list = LP_DELIM_SP;
      LP_DELIM_SP: begin
        if (c == CH_SPACE) pk_list = LP_OPEN_Q;
        else pk_list = LP_NONE;
      end
      LP_OPEN_Q: begin
        if (c == CH_QUOTE) begin
          pk_list = LP_NAME;
          pk_folder = 1'b1;
        end else begin
          pk_list = LP_NONE;
        end
      end
      LP_NAME: begin
        if (c == CH_QUOTE) begin
          pk_list = LP_NAME_END;
        end else begin
          r.name_byte = c;
          r.name_valid = 1'b1;
        end
      end
      default: ;
    endcase

    // attribute scan inside the parentheses
    if (pk_attr == AP_SEEK) begin
      if (c == CH_LPAREN) begin
        pk_attr = AP_IN_PARENS;
        pk_flag_pos = FLAG_BOUNDARY;
      end
    end else if (pk_attr == AP_IN_PARENS) begin
      f = pk_flag_pos;
      if (f == FLAG_BOUNDARY) begin
        if (c == CH_RPAREN) pk_attr = AP_DONE;
        else if (c != CH_SPACE) f = (c == NOSEL_WORD[0]) ? 4'd1 : FLAG_SKIP;
      end else if (f == FLAG_SKIP) begin
        if (c == CH_SPACE) f = FLAG_BOUNDARY;
        else if (c == CH_RPAREN) pk_attr = AP_DONE;
      end else if (f < FLAG_FULL) begin
        if (c == NOSEL_WORD[f]) begin
          f = f + 4'd1;
          if (f == FLAG_FULL) begin
            pk_nosel = 1'b1;
            pk_attr = AP_DONE;
          end
        end else if (c == CH_SPACE) begin
          f = FLAG_BOUNDARY;
        end else if (c == CH_RPAREN) begin
          pk_attr = AP_DONE;
        end else begin
          f = FLAG_SKIP;
        end
      end
      pk_flag_pos = f;
    end

    // "* LIST " prefix
    if (pk_list == LP_PREFIX) begin
      if (pk_pos < LIST_LEN && c == LIST_WORD[pk_pos[2:0]]) begin
        if (pk_pos == LIST_LEN - 4'd1) begin
          pk_list = LP_SEEK_CLOSE;
          pk_attr = AP_SEEK;
          pk_list_line = 1'b1;
        end
      end else begin
        pk_list = LP_NONE;
      end
    end

    if (pk_pos < POS_MAX) pk_pos = pk_pos + 4'd1;

    r.line_done = lst;
    if (lst) begin
      r.line_class = CLASS_UNKNOWN;
      if (pk_kind == LK_UNTAGGED) r.line_class = CLASS_UNTAGGED;
      else if (pk_kind == LK_TAG && pk_tag_st == TS_MATCHED) r.line_class = CLASS_TAGGED;
      r.tag_ok = pk_tag_ok;
      r.list_line = pk_list_line;
      r.folder_found = pk_folder;
      r.noselect = pk_nosel;
      clear_parse_state();
    end
    return r;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk) begin
    line_result_t got, want, pred;
    if (rst) begin
      clear_parse_state();
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {name_byte, name_valid, line_done, line_class,
               tag_ok, list_line, folder_found, noselect};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: byte=%h v=%b done=%b class=%0d",
                     got.name_byte, got.name_valid, got.line_done, got.line_class);
        end else begin
          want = expected_results.pop_front();
          if (got.name_byte !== want.name_byte || got.name_valid !== want.name_valid ||
              got.line_done !== want.line_done || got.line_class !== want.line_class ||
              got.tag_ok !== want.tag_ok || got.list_line !== want.list_line ||
              got.folder_found !== want.folder_found || got.noselect !== want.noselect) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch exp: byte=%h v=%b done=%b class=%0d ok=%b list=%b fold=%b nosel=%b",
                       want.name_byte, want.name_valid, want.line_done, want.line_class,
                       want.tag_ok, want.list_line, want.folder_found, want.noselect);
              $display("         got: byte=%h v=%b done=%b class=%0d ok=%b list=%b fold=%b nosel=%b",
                       got.name_byte, got.name_valid, got.line_done, got.line_class,
                       got.tag_ok, got.list_line, got.folder_found, got.noselect);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = parse_byte(char_in, last);
        expected_results.push_back(row_typed ? row_exp : pred);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAIL imap_response_line_parser");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stalls, with quiet stretches
  initial begin
    int stall;
    int taken;
    bit rx_quiet;
    taken = 0;
    rx_quiet = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endfunction

  // sends byte_q as one line; typed lines carry their expectation along
  task automatic send_line(input bit quiet, input bit typed, input logic [1:0] cls,
                           input logic [3:0] flg);
    int           gap;
    logic         fin;
    line_result_t te;
    for (int i = 0; i < byte_q.size(); i++) begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      fin = (i == byte_q.size() - 1);
      te = '0;
      te.line_done = fin;
      if (fin) begin
        te.line_class = cls;
        {te.noselect, te.folder_found, te.list_line, te.tag_ok} = flg;
      end
      char_in <= byte_q[i];
      last <= fin;
      in_valid <= 1'b1;
      row_typed <= typed;
      row_exp <= te;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    bytes_sent += byte_q.size();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_tag(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tag_shadow = v;
  endtask

  task automatic build_random_line();
    int          sel, n;
    logic [63:0] tag_val;
    logic [7:0]  b;
    byte_q.delete();
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      put_str("* LIST ");
      if ($urandom_range(0, 9) != 0) byte_q.push_back("(");
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
        if (k > 0) put_str(($urandom_range(0, 4) == 0) ? "  " : " ");
        case ($urandom_range(0, 6))
          0, 1: put_str("\\Noselect");
          2: put_str("\\HasNoChildren");
          3: put_str("\\Noselec");
          4: put_str("\\Noselectx");
          5: put_str("\\No)x");   // close paren inside a token
          default: begin
            repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(33, 126)));
          end
        endcase
      end
      byte_q.push_back(")");
      repeat ($urandom_range(0, 2)) byte_q.push_back(" ");
      if ($urandom_range(0, 7) == 0) begin
        put_str("NIL ");
      end else begin
        do b = rand_byte(); while (b == CH_QUOTE);
        byte_q.push_back(CH_QUOTE);
        byte_q.push_back(b);
        byte_q.push_back(CH_QUOTE);
        byte_q.push_back(($urandom_range(0, 9) == 0) ? rand_byte() : CH_SPACE);
      end
      byte_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
        do b = rand_byte(); while (b == CH_QUOTE);
        byte_q.push_back(b);
      end
      if ($urandom_range(0, 4) != 0) byte_q.push_back(CH_QUOTE);
      if ($urandom_range(0, 4) == 0) put_str(" x");
    end else if (sel < 65) begin
      n = $urandom_range(0, 99);
      if (n < 60) tag_val = {32'h0, tag_shadow};
      else if (n < 75) tag_val = {32'h0, $urandom()};
      else if (n < 85) tag_val = 64'h1_0000_0000 + $urandom();  // past 32 bits
      else tag_val = $urandom_range(0, 999);
      if (n >= 85) byte_q.push_back("0");                       // leading zero
      put_str($sformatf("%0d", tag_val));
      byte_q.push_back(($urandom_range(0, 9) == 0) ? rand_byte() : CH_SPACE);
      case ($urandom_range(0, 4))
        0, 1, 2: put_str("OK ");
        3: put_str("NO ");
        default: put_str("OK");
      endcase
      repeat ($urandom_range(0, 4)) byte_q.push_back(8'($urandom_range(32, 126)));
    end else if (sel < 80) begin
      put_str(($urandom_range(0, 2) == 0) ? "* LIS" : "* ");
      repeat ($urandom_range(0, 6)) byte_q.push_back(8'($urandom_range(32, 126)));
    end else begin
      repeat ($urandom_range(1, 6)) byte_q.push_back(rand_byte());
    end
    // occasional damage to a well-formed line
    if (sel < 65 && $urandom_range(0, 9) == 0)
      byte_q[$urandom_range(0, byte_q.size() - 1)] = rand_byte();
  endtask

  typedef struct {
    string      text;
    logic [7:0] tail;
    logic       typed;
    logic [1:0] cls;
    logic [3:0] flg;   // {noselect, folder_found, list_line, tag_ok}
  } dir_row_t;

  dir_row_t dir_rows [0:6];

  initial begin
    logic [31:0] tag_plan [0:4];
    int          phase_end;
    dir_rows = '{
      '{"", "*", 1'b1, CLASS_UNKNOWN, 4'b0000},       // line ends inside the prefix
      '{"*", " ", 1'b1, CLASS_UNTAGGED, 4'b0000},
      '{"0 OK", " ", 1'b1, CLASS_TAGGED, 4'b0001},    // reset tag is zero
      '{"01", " ", 1'b1, CLASS_UNKNOWN, 4'b0000},     // leading zero on the tag
      '{"", 8'h00, 1'b1, CLASS_UNKNOWN, 4'b0000},
      '{"", 8'hFF, 1'b1, CLASS_UNKNOWN, 4'b0000},
      '{"* LIST (\\Noselect) \"/\" \"", "a", 1'b0, CLASS_UNTAGGED, 4'b0000}  // name unclosed
    };
    tag_plan[0] = 32'hFFFF_FFFF;
    tag_plan[1] = $urandom_range(1, 20);
    tag_plan[2] = $urandom();
    tag_plan[3] = 32'h0;
    tag_plan[4] = $urandom_range(0, 999999);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < 7; r++) begin
      byte_q.delete();
      put_str(dir_rows[r].text);
      byte_q.push_back(dir_rows[r].tail);
      send_line(1'b0, dir_rows[r].typed, dir_rows[r].cls, dir_rows[r].flg);
    end

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      set_tag(tag_plan[ph]);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_random_line();
        send_line($urandom_range(0, 3) == 0, 1'b0, CLASS_UNTAGGED, 4'b0000);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS imap_response_line_parser");
    end else begin
      $display("FAIL imap_response_line_parser");
    end
    $finish;
  end

endmodule
